// File: rtl/circle_edge_deviation_accumulator_top_macros.svh
// Assertion shorthands used by the checker file of this block.
`ifndef CIRCLE_EDGE_DEVIATION_ACCUMULATOR_TOP_MACROS_SVH
`define CIRCLE_EDGE_DEVIATION_ACCUMULATOR_TOP_MACROS_SVH

// Consequence must hold in the same cycle as the condition.
`define CEDACC_ASSERT_SAME(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("same-cycle check failed");

// Consequence must hold in the cycle after the condition.
`define CEDACC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/cedacc_pkg.sv
package cedacc_pkg;

  // Fixed field widths.
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int EDGE_W      = 8;
  localparam int SUM_W       = 40;
  localparam int MEAN_W      = 16;
  localparam int OUT_COUNT_W = 24;

  localparam logic [EDGE_W-1:0] EDGE_MARK = 8'hFF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS   = 2'd2
  } cfg_reg_e;

  // Status of an iterative unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Distance unit sequencer.
  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_SQR  = 3'b010,
    D_ROOT = 3'b100
  } dist_state_e;

  // Top-level sequencer.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIST = 5'b00010,
    S_ACC  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } top_state_e;

endpackage

// File: rtl/cedacc_dist.sv
module cedacc_dist import cedacc_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COORD_BITS-1:0] pixel_x_i,
  input  logic [COORD_BITS-1:0] pixel_y_i,
  input  logic [CFG_W-1:0]      center_x_i,
  input  logic [CFG_W-1:0]      center_y_i,
  output logic [((COORD_BITS + 4 > CFG_W) ? COORD_BITS + 4 : CFG_W):0] root_o,
  output unit_stat_t            stat_o
);

  // Offset width, root width and counter width.
  localparam int DW    = (COORD_BITS + 4 > CFG_W) ? COORD_BITS + 4 : CFG_W;
  localparam int RW    = DW + 1;
  localparam int CNT_W = $clog2(RW);

  dist_state_e     state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DW-1:0]   dx_q, dy_q, mx_q, my_q;
  logic [2*RW-1:0] acc_q;
  logic [RW:0]     rem_q;
  logic [RW-1:0]   root_q;

  logic [DW-1:0]   px, py, dx, dy;
  logic [2*RW-1:0] sq_next;
  logic [RW+2:0]   pre, trial;
  logic            fits;

  // Pixel position in Q12.4 and absolute offsets from the centre.
  assign px = DW'({pixel_x_i, 4'b0000});
  assign py = DW'({pixel_y_i, 4'b0000});
  assign dx = (px >= DW'(center_x_i)) ? px - DW'(center_x_i) : DW'(center_x_i) - px;
  assign dy = (py >= DW'(center_y_i)) ? py - DW'(center_y_i) : DW'(center_y_i) - py;

  // One multiplier bit of both squares per cycle, most significant first.
  assign sq_next = {acc_q[2*RW-2:0], 1'b0}
                 + (mx_q[DW-1] ? (2*RW)'(dx_q) : '0)
                 + (my_q[DW-1] ? (2*RW)'(dy_q) : '0);

  // One root bit per cycle: trial subtraction of 4*root + 1.
  assign pre   = {rem_q, acc_q[2*RW-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign fits  = (pre >= trial);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      D_IDLE: begin
        if (start_i) begin
          state_d = D_SQR;
          cnt_d   = CNT_W'(DW - 1);
        end
      end
      D_SQR: begin
        if (cnt_q == '0) begin
          state_d = D_ROOT;
          cnt_d   = CNT_W'(RW - 1);
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      D_ROOT: begin
        if (cnt_q == '0) begin
          state_d = D_IDLE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: begin
        state_d = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk_i) begin
    if (state_q == D_IDLE && start_i) begin
      dx_q   <= dx;
      dy_q   <= dy;
      mx_q   <= dx;
      my_q   <= dy;
      acc_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else if (state_q == D_SQR) begin
      acc_q <= sq_next;
      mx_q  <= {mx_q[DW-2:0], 1'b0};
      my_q  <= {my_q[DW-2:0], 1'b0};
    end else if (state_q == D_ROOT) begin
      acc_q <= {acc_q[2*RW-3:0], 2'b00};
      if (fits) begin
        rem_q  <= (RW+1)'(pre - trial);
        root_q <= {root_q[RW-2:0], 1'b1};
      end else begin
        rem_q  <= pre[RW:0];
        root_q <= {root_q[RW-2:0], 1'b0};
      end
    end
  end

  assign root_o      = root_q;
  assign stat_o.busy = (state_q != D_IDLE);
  assign stat_o.done = (state_q == D_ROOT) && (cnt_q == '0);

endmodule

// File: rtl/cedacc_div.sv
module cedacc_div import cedacc_pkg::*; #(
  parameter int DIV_W = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic [SUM_W-1:0] quot_o,
  output unit_stat_t       stat_o
);

  localparam int CNT_W = $clog2(SUM_W);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0] quot_q;
  logic [DIV_W-1:0] rem_q, dvs_q;
  logic [DIV_W:0]   part;
  logic             fits;

  // Restoring division, one quotient bit per cycle.
  assign part = {rem_q, quot_q[SUM_W-1]};
  assign fits = (part >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (!busy_q && start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(SUM_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && start_i) begin
      quot_q <= dividend_i;
      dvs_q  <= divisor_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q  <= DIV_W'(part - {1'b0, dvs_q});
        quot_q <= {quot_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_q  <= part[DIV_W-1:0];
        quot_q <= {quot_q[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign quot_o      = quot_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (cnt_q == '0);

endmodule

// File: rtl/circle_edge_deviation_accumulator_top.sv
// Circle edge deviation accumulator.
// Input channel: one edge pixel per request (pixel_x_i, pixel_y_i, edge_value_i,
// frame_last_i), taken when in_valid_i is high and in_stall_o is low.
// Output channel: one result per frame (mean_deviation_o, edge_count_o,
// no_points_o), taken when out_valid_o is high and out_stall_i is low.
// Configuration: centre and radius in Q12.4, to be written by the user through
// cfg_we_i, cfg_index_i and cfg_data_i while the block is idle; not enforced.
// Pixels are taken one at a time: in_stall_o stays high until the block is
// through with the one it took. DW = max(COORD_BITS + 4, 16) and RW = DW + 1.
// The sum of squares takes one multiplier bit a cycle and the square root one
// root bit a cycle. The frame's last pixel also runs the bit-serial mean
// divider before its result is loaded into the output register.
// The result sits in an output register; a stalled result holds its value,
// and the block finishes the next pixels meanwhile, waiting only when the
// next frame result is ready before the previous one has been taken.
// Reset clears the configuration, the running sum, the count and the
// result valid flag; no clearing pass is needed.
module circle_edge_deviation_accumulator_top import cedacc_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int COUNT_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [COORD_BITS-1:0]  pixel_x_i,
  input  logic [COORD_BITS-1:0]  pixel_y_i,
  input  logic [EDGE_W-1:0]      edge_value_i,
  input  logic                   frame_last_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [MEAN_W-1:0]      mean_deviation_o,
  output logic [OUT_COUNT_W-1:0] edge_count_o,
  output logic                   no_points_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i
);

  localparam int RW   = COORD_BITS + 5 > CFG_W + 1 ? COORD_BITS + 5 : CFG_W + 1;
  localparam int CX_W = COUNT_BITS > OUT_COUNT_W ? COUNT_BITS : OUT_COUNT_W;
  localparam int OUT_COUNT_MAX = 2 ** OUT_COUNT_W - 1;

  top_state_e            state_q, state_d;
  logic [CFG_W-1:0]      center_x_q, center_y_q, radius_q;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  edge_q, last_q;
  logic                  out_valid_q;
  logic [MEAN_W-1:0]     mean_q;
  logic [OUT_COUNT_W-1:0] ecount_q;
  logic                  nopts_q;

  logic                  in_take, out_free, load_out;
  logic [RW-1:0]         root;
  unit_stat_t            dist_stat, div_stat;
  logic [SUM_W-1:0]      quot;
  logic [RW-1:0]         dev;
  logic [RW+3:0]         dev10;
  logic                  hit;
  logic [SUM_W:0]        sum_add;
  logic [CX_W-1:0]       count_ext;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (state_q == S_OUT) && out_free;

  // Configuration registers; an unknown index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      radius_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CENTER_X: center_x_q <= cfg_data_i;
        REG_CENTER_Y: center_y_q <= cfg_data_i;
        REG_RADIUS:   radius_q   <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  cedacc_dist #(
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_take),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .root_o     (root),
    .stat_o     (dist_stat)
  );

  // Deviation from the radius and the band test.
  assign dev   = (RW'(root) >= RW'(radius_q)) ? RW'(root) - RW'(radius_q)
                                              : RW'(radius_q) - RW'(root);
  assign dev10 = (RW+4)'({dev, 3'b000}) + (RW+4)'({dev, 1'b0});
  assign hit   = edge_q && (dev10 < (RW+4)'(radius_q)) && (count_q != '1);
  assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(dev);

  // Running sum and count.
  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    if (state_q == S_ACC && hit) begin
      sum_d   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      count_d = count_q + 1'b1;
    end else if (load_out) begin
      sum_d   = '0;
      count_d = '0;
    end
  end

  cedacc_div #(
    .DIV_W(COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    ((state_q == S_ACC) && last_q),
    .dividend_i (sum_d),
    .divisor_i  (count_d),
    .quot_o     (quot),
    .stat_o     (div_stat)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_take) state_d = S_DIST;
      S_DIST: if (dist_stat.done) state_d = S_ACC;
      S_ACC:  state_d = last_q ? S_DIV : S_IDLE;
      S_DIV:  if (div_stat.done) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      count_q     <= '0;
      edge_q      <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      count_q <= count_d;
      if (in_take) begin
        edge_q <= (edge_value_i == EDGE_MARK);
        last_q <= frame_last_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register: mean and count saturate to the field widths.
  assign count_ext = CX_W'(count_q);

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      nopts_q <= (count_q == '0);
      if (count_q == '0) begin
        mean_q <= '0;
      end else if (quot[SUM_W-1:MEAN_W] != '0) begin
        mean_q <= '1;
      end else begin
        mean_q <= quot[MEAN_W-1:0];
      end
      if (count_ext > CX_W'(OUT_COUNT_MAX)) begin
        ecount_q <= '1;
      end else begin
        ecount_q <= count_ext[OUT_COUNT_W-1:0];
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign mean_deviation_o = mean_q;
  assign edge_count_o     = ecount_q;
  assign no_points_o      = nopts_q;

endmodule

// File: rtl/cedacc_checker.sv
`include "circle_edge_deviation_accumulator_top_macros.svh"

module cedacc_checker import cedacc_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [MEAN_W-1:0]      mean_deviation_o,
  input logic [OUT_COUNT_W-1:0] edge_count_o,
  input logic                   no_points_o
);

  // An empty frame reports a zero mean and a zero count.
  `CEDACC_ASSERT_SAME(a_empty_zero, clk_i, rst_ni, out_valid_o && no_points_o, mean_deviation_o == '0 && edge_count_o == '0)

  // A frame with counted pixels never reports a zero count.
  `CEDACC_ASSERT_SAME(a_count_nonzero, clk_i, rst_ni, out_valid_o && !no_points_o, edge_count_o != '0)

  // A pixel request keeps the block busy in the following cycle.
  `CEDACC_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A stalled result stays offered unchanged.
  `CEDACC_ASSERT_NEXT(a_result_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(mean_deviation_o) && $stable(edge_count_o) && $stable(no_points_o))

endmodule

bind circle_edge_deviation_accumulator_top cedacc_checker u_cedacc_checker (.*);
